[rtl/bte_pkg.sv]
// shared types, constants and helpers for the bitmap transform engine
// no dependencies; imported by bte_csr, bte_addr and the engine top level
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = $clog2(MAX_DIM + 1);
   localparam int CNT_W       = $clog2(MAX_DIM);
   localparam int COORD_W     = SIZE_W + 2;

   localparam int PIXEL_W     = 24;
   localparam int CFG_SIZE_W  = 7;
   localparam int CFG_SHIFT_W = 7;
   localparam int CFG_MODE_W  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [7:0] CHANNEL_MAX = 8'hff;
   localparam logic [PIXEL_W-1:0] INVERT_MASK = {CHANNEL_MAX, CHANNEL_MAX, CHANNEL_MAX};

   typedef enum logic [CFG_MODE_W-1:0] {
      MODE_FLIP_H    = 3'd0,
      MODE_FLIP_V    = 3'd1,
      MODE_ROT_LEFT  = 3'd2,
      MODE_ROT_RIGHT = 3'd3,
      MODE_SHIFT     = 3'd4,
      MODE_INVERT    = 3'd5,
      MODE_CROP_PAD  = 3'd6,
      MODE_PASS      = 3'd7
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_TRANSFORM_MODE = 3'd2,
      CSR_SHIFT_X        = 3'd3,
      CSR_SHIFT_Y        = 3'd4,
      CSR_NEW_WIDTH      = 3'd5,
      CSR_NEW_HEIGHT     = 3'd6,
      CSR_FILL_COLOR     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               func;
      logic [PIXEL_W-1:0] pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [SIZE_W-1:0]             frame_w;
      logic [SIZE_W-1:0]             frame_h;
      logic [SIZE_W-1:0]             new_w;
      logic [SIZE_W-1:0]             new_h;
      mode_type                      mode;
      logic signed [CFG_SHIFT_W-1:0] shift_x;
      logic signed [CFG_SHIFT_W-1:0] shift_y;
      logic [PIXEL_W-1:0]            fill_color;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctrl_type;

   typedef struct packed {
      logic use_fill;
      logic invert;
      logic last;
   } rd_meta_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] raw,
                                                    input int unsigned max_size);
      logic [SIZE_W-1:0] res;
      if (raw == '0) begin
         res = SIZE_W'(1);
      end else if (32'(raw) > max_size) begin
         res = SIZE_W'(max_size);
      end else begin
         res = SIZE_W'(raw);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/bte_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bte_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/bte_csr.sv]
// configuration registers with size clamping
// depends on bte_pkg
`timescale 1ns / 1ps
`default_nettype none

module bte_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [bte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bte_pkg::CSR_DATA_W-1:0]  csr_data,
   output bte_pkg::cfg_type                     cfg
);
   import bte_pkg::*;

   logic [CFG_SIZE_W-1:0]  frame_width_ff, frame_width_in;
   logic [CFG_SIZE_W-1:0]  frame_height_ff, frame_height_in;
   logic [CFG_MODE_W-1:0]  mode_ff, mode_in;
   logic [CFG_SHIFT_W-1:0] shift_x_ff, shift_x_in;
   logic [CFG_SHIFT_W-1:0] shift_y_ff, shift_y_in;
   logic [CFG_SIZE_W-1:0]  new_width_ff, new_width_in;
   logic [CFG_SIZE_W-1:0]  new_height_ff, new_height_in;
   logic [PIXEL_W-1:0]     fill_color_ff, fill_color_in;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      mode_in         = mode_ff;
      shift_x_in      = shift_x_ff;
      shift_y_in      = shift_y_ff;
      new_width_in    = new_width_ff;
      new_height_in   = new_height_ff;
      fill_color_in   = fill_color_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:    frame_width_in  = csr_data[CFG_SIZE_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_in = csr_data[CFG_SIZE_W-1:0];
            CSR_TRANSFORM_MODE: mode_in         = csr_data[CFG_MODE_W-1:0];
            CSR_SHIFT_X:        shift_x_in      = csr_data[CFG_SHIFT_W-1:0];
            CSR_SHIFT_Y:        shift_y_in      = csr_data[CFG_SHIFT_W-1:0];
            CSR_NEW_WIDTH:      new_width_in    = csr_data[CFG_SIZE_W-1:0];
            CSR_NEW_HEIGHT:     new_height_in   = csr_data[CFG_SIZE_W-1:0];
            CSR_FILL_COLOR:     fill_color_in   = csr_data[PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_SIZE_W'(64);
         frame_height_ff <= CFG_SIZE_W'(64);
         mode_ff         <= MODE_FLIP_H;
         shift_x_ff      <= '0;
         shift_y_ff      <= '0;
         new_width_ff    <= CFG_SIZE_W'(64);
         new_height_ff   <= CFG_SIZE_W'(64);
         fill_color_ff   <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         mode_ff         <= mode_in;
         shift_x_ff      <= shift_x_in;
         shift_y_ff      <= shift_y_in;
         new_width_ff    <= new_width_in;
         new_height_ff   <= new_height_in;
         fill_color_ff   <= fill_color_in;
      end
   end

   always_comb begin
      cfg.frame_w    = clamp_size(frame_width_ff, MAX_WIDTH);
      cfg.frame_h    = clamp_size(frame_height_ff, MAX_HEIGHT);
      cfg.new_w      = clamp_size(new_width_ff, MAX_WIDTH);
      cfg.new_h      = clamp_size(new_height_ff, MAX_HEIGHT);
      cfg.mode       = mode_type'(mode_ff);
      cfg.shift_x    = $signed(shift_x_ff);
      cfg.shift_y    = $signed(shift_y_ff);
      cfg.fill_color = fill_color_ff;
   end

endmodule

`default_nettype wire

[rtl/bte_addr.sv]
// load and readout counters, source coordinate mapping and store address
// depends on bte_pkg
`timescale 1ns / 1ps
`default_nettype none

module bte_addr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_accept,
   input  wire logic                  read_accept,
   input  wire bte_pkg::cfg_type      cfg,
   output bte_pkg::ram_ctrl_type      ram_ctrl,
   output bte_pkg::rd_meta_type       rd_meta
);
   import bte_pkg::*;

   localparam logic signed [COORD_W-1:0] OneS = COORD_W'(1);

   logic [ADDR_W-1:0] load_index_ff, load_index_in;
   logic [CNT_W-1:0]  out_column_ff, out_column_in;
   logic [CNT_W-1:0]  out_row_ff, out_row_in;

   logic [ADDR_W:0]          load_inc;
   logic [2*SIZE_W-1:0]      frame_area;
   logic [SIZE_W-1:0]        out_w;
   logic [SIZE_W-1:0]        out_h;
   logic [CNT_W:0]           col_inc;
   logic [CNT_W:0]           row_inc;
   logic                     col_wrap;
   logic                     row_wrap;
   logic signed [COORD_W-1:0] ox_s, oy_s, w_s, h_s, shx_s, shy_s, sx_s, sy_s;
   logic                     in_frame;
   logic [CNT_W+SIZE_W-1:0]  row_base;

   // load side
   always_comb begin
      frame_area    = cfg.frame_w * cfg.frame_h;
      load_inc      = {1'b0, load_index_ff} + (ADDR_W+1)'(1);
      load_index_in = load_index_ff;
      if (load_accept) begin
         load_index_in = (load_inc >= frame_area) ? '0 : load_inc[ADDR_W-1:0];
      end
   end

   // output size and source mapping
   always_comb begin
      out_w = cfg.frame_w;
      out_h = cfg.frame_h;
      unique case (cfg.mode)
         MODE_ROT_LEFT, MODE_ROT_RIGHT: begin
            out_w = cfg.frame_h;
            out_h = cfg.frame_w;
         end
         MODE_CROP_PAD: begin
            out_w = cfg.new_w;
            out_h = cfg.new_h;
         end
         default: ;
      endcase

      ox_s  = $signed({{(COORD_W-CNT_W){1'b0}}, out_column_ff});
      oy_s  = $signed({{(COORD_W-CNT_W){1'b0}}, out_row_ff});
      w_s   = $signed({{(COORD_W-SIZE_W){1'b0}}, cfg.frame_w});
      h_s   = $signed({{(COORD_W-SIZE_W){1'b0}}, cfg.frame_h});
      shx_s = $signed({{(COORD_W-CFG_SHIFT_W){cfg.shift_x[CFG_SHIFT_W-1]}}, cfg.shift_x});
      shy_s = $signed({{(COORD_W-CFG_SHIFT_W){cfg.shift_y[CFG_SHIFT_W-1]}}, cfg.shift_y});

      unique case (cfg.mode)
         MODE_FLIP_H: begin
            sx_s = w_s - OneS - ox_s;
            sy_s = oy_s;
         end
         MODE_FLIP_V: begin
            sx_s = ox_s;
            sy_s = h_s - OneS - oy_s;
         end
         MODE_ROT_LEFT: begin
            sx_s = w_s - OneS - oy_s;
            sy_s = ox_s;
         end
         MODE_ROT_RIGHT: begin
            sx_s = oy_s;
            sy_s = h_s - OneS - ox_s;
         end
         MODE_SHIFT: begin
            sx_s = ox_s - shx_s;
            sy_s = oy_s - shy_s;
         end
         MODE_INVERT, MODE_CROP_PAD, MODE_PASS: begin
            sx_s = ox_s;
            sy_s = oy_s;
         end
         default: begin
            sx_s = ox_s;
            sy_s = oy_s;
         end
      endcase

      in_frame = !sx_s[COORD_W-1] && !sy_s[COORD_W-1] && (sx_s < w_s) && (sy_s < h_s);
      row_base = sy_s[CNT_W-1:0] * cfg.frame_w;
   end

   // readout counters
   always_comb begin
      col_inc       = {1'b0, out_column_ff} + (CNT_W+1)'(1);
      row_inc       = {1'b0, out_row_ff} + (CNT_W+1)'(1);
      col_wrap      = col_inc >= out_w;
      row_wrap      = row_inc >= out_h;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (read_accept) begin
         if (col_wrap) begin
            out_column_in = '0;
            out_row_in    = row_wrap ? '0 : row_inc[CNT_W-1:0];
         end else begin
            out_column_in = col_inc[CNT_W-1:0];
            out_row_in    = (out_row_ff >= out_h) ? '0 : out_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else begin
         load_index_ff <= load_index_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

   always_comb begin
      ram_ctrl.wr_en    = load_accept;
      ram_ctrl.wr_addr  = load_index_ff;
      ram_ctrl.rd_en    = read_accept;
      ram_ctrl.rd_addr  = ADDR_W'(row_base + (CNT_W+SIZE_W)'(sx_s[CNT_W-1:0]));
      rd_meta.use_fill  = !in_frame;
      rd_meta.invert    = (cfg.mode == MODE_INVERT);
      rd_meta.last      = col_wrap && row_wrap;
   end

endmodule

`default_nettype wire

[rtl/bitmap_transform_engine_unit.sv]
// top level of the bitmap transform engine: handshake, pixel store and output register
// depends on bte_pkg, bte_csr, bte_addr and bte_ram
`timescale 1ns / 1ps
`default_nettype none

// Holds one RGB888 frame of up to 64 x 64 pixels in a single-port-write,
// registered-read store. Load requests (func 0) write the next pixel in raster
// order and produce no response; read requests (func 1) return the next pixel
// of the transformed frame in output raster order, with last_out on the final
// pixel. One request is taken per cycle while req_stall is low; a read
// response passes through the store's registered read and then the output
// register. Requests stall only while a read waits behind an output
// that is not taken. Store entries are not cleared after reset; read only
// what has been loaded. Configure only while no read is outstanding.
module bitmap_transform_engine_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bte_pkg::req_payload_type        req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bte_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                            csr_wr_en,
   input  wire logic [bte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bte_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bte_pkg::*;

   cfg_type         cfg;
   ram_ctrl_type    ram_ctrl;
   rd_meta_type     rd_meta;
   logic [PIXEL_W-1:0] rd_data;

   logic            s1_valid_ff, s1_valid_in;
   rd_meta_type     s1_meta_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic            s1_advance;
   logic            req_accept;
   logic            load_accept;
   logic            read_accept;
   logic [PIXEL_W-1:0] pixel_sel;

   bte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bte_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .load_accept (load_accept),
      .read_accept (read_accept),
      .cfg         (cfg),
      .ram_ctrl    (ram_ctrl),
      .rd_meta     (rd_meta)
   );

   bte_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (req_payload.pixel_in),
      .rd_en   (ram_ctrl.rd_en),
      .rd_addr (ram_ctrl.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_advance  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall   = s1_valid_ff && !s1_advance;
      req_accept  = req_valid && !req_stall;
      load_accept = req_accept && !req_payload.func;
      read_accept = req_accept && req_payload.func;

      s1_valid_in = s1_valid_ff;
      if (read_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      pixel_sel = (s1_meta_ff.use_fill ? cfg.fill_color : rd_data)
                ^ (s1_meta_ff.invert ? INVERT_MASK : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read_accept) begin
         s1_meta_ff <= rd_meta;
      end
      if (s1_advance) begin
         rsp_payload_ff.pixel_out <= pixel_sel;
         rsp_payload_ff.last_out  <= s1_meta_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[test/tb_bitmap_transform_engine_unit.sv]
`timescale 1ns / 1ps
// testbench for bitmap_transform_engine_unit: loads small frames, reads them back through
// every transform and checks each pixel against a frame predictor kept alongside
// depends on bte_pkg and the engine rtl
module tb_bitmap_transform_engine_unit;
   import bte_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 250;
   localparam int HOLD_CYCLES = 300;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bitmap_transform_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // frame predictor state
   logic [PIXEL_W-1:0] frame_store [STORE_DEPTH];
   int load_ptr = 0;
   int out_col = 0;
   int out_row = 0;
   logic [CFG_SIZE_W-1:0] frame_w_raw = 7'd64;
   logic [CFG_SIZE_W-1:0] frame_h_raw = 7'd64;
   logic [CFG_SIZE_W-1:0] new_w_raw = 7'd64;
   logic [CFG_SIZE_W-1:0] new_h_raw = 7'd64;
   mode_type xform_mode = MODE_FLIP_H;
   logic signed [CFG_SHIFT_W-1:0] shift_x_reg = '0;
   logic signed [CFG_SHIFT_W-1:0] shift_y_reg = '0;
   logic [PIXEL_W-1:0] fill_reg = '0;

   rsp_payload_type expected_pixels[$];
   req_payload_type pending_requests[$];
   logic [PIXEL_W-1:0] directed_pixels[$];

   int error_count = 0;
   int loads_done = 0;
   int reads_done = 0;
   int frames_done = 0;
   int phases_run = 0;
   int items_queued = 0;
   bit hold_request = 1'b0;

   function automatic int dim(input logic [CFG_SIZE_W-1:0] raw, input int lim);
      if (raw == '0) return 1;
      if (int'(raw) > lim) return lim;
      return int'(raw);
   endfunction

   function automatic logic [PIXEL_W-1:0] source_pixel(input int sx, sy, w, h);
      if (sx < 0 || sy < 0 || sx >= w || sy >= h) return fill_reg;
      return frame_store[sy * w + sx];
   endfunction

   task automatic predict_request(input req_payload_type r);
      int w, h, ow, oh, ox, oy;
      logic [PIXEL_W-1:0] pix;
      rsp_payload_type want;
      w = dim(frame_w_raw, MAX_WIDTH);
      h = dim(frame_h_raw, MAX_HEIGHT);
      if (r.func == FUNC_LOAD) begin
         frame_store[load_ptr] = r.pixel_in;
         load_ptr++;
         if (load_ptr >= w * h) load_ptr = 0;
         loads_done++;
      end else begin
         ow = w;
         oh = h;
         if (xform_mode == MODE_ROT_LEFT || xform_mode == MODE_ROT_RIGHT) begin
            ow = h;
            oh = w;
         end else if (xform_mode == MODE_CROP_PAD) begin
            ow = dim(new_w_raw, MAX_WIDTH);
            oh = dim(new_h_raw, MAX_HEIGHT);
         end
         ox = out_col;
         oy = out_row;
         case (xform_mode)
            MODE_FLIP_H: pix = source_pixel(w - 1 - ox, oy, w, h);
            MODE_FLIP_V: pix = source_pixel(ox, h - 1 - oy, w, h);
            MODE_ROT_LEFT: pix = source_pixel(w - 1 - oy, ox, w, h);
            MODE_ROT_RIGHT: pix = source_pixel(oy, h - 1 - ox, w, h);
            MODE_SHIFT: pix = source_pixel(ox - int'(shift_x_reg), oy - int'(shift_y_reg), w, h);
            MODE_INVERT: pix = source_pixel(ox, oy, w, h) ^ INVERT_MASK;
            default: pix = source_pixel(ox, oy, w, h);
         endcase
         want.pixel_out = pix;
         want.last_out = (ox + 1 >= ow) && (oy + 1 >= oh);
         if (ox + 1 >= ow) begin
            out_col = 0;
            out_row = (oy + 1 >= oh) ? 0 : oy + 1;
         end else begin
            out_col = ox + 1;
            if (oy >= oh) out_row = 0;
         end
         expected_pixels.push_back(want);
         reads_done++;
         if (want.last_out) frames_done++;
      end
   endtask

   // request driver: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_request(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_requests.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern, with one long hold on request
   int hold_left = 0;
   int style_left = 0;
   int stall_style = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (style_left == 0) begin
            style_left = $urandom_range(16, 96);
            stall_style = $urandom_range(0, 3);
         end
         style_left--;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected response pixel_out %h last_out %b",
                   rsp_payload.pixel_out, rsp_payload.last_out);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.pixel_out !== want.pixel_out) begin
               $error("pixel_out expected %h actual %h", want.pixel_out, rsp_payload.pixel_out);
               error_count++;
            end
            if (rsp_payload.last_out !== want.last_out) begin
               $error("last_out expected %b actual %b", want.last_out, rsp_payload.last_out);
               error_count++;
            end
         end
      end
   end

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [PIXEL_W-1:0] next_pixel();
      if (directed_pixels.size() > 0) return directed_pixels.pop_front();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return $urandom_range(65, 127);
         2: return 64;
         default: return $urandom_range(1, 9);
      endcase
   endfunction

   function automatic int pick_shift();
      case ($urandom_range(0, 4))
         0: return -63;
         1: return 63;
         default: return int'($urandom_range(0, 126)) - 63;
      endcase
   endfunction

   task automatic queue_request(input logic func, input logic [PIXEL_W-1:0] pixel);
      req_payload_type r;
      r.func = func;
      r.pixel_in = pixel;
      pending_requests.push_back(r);
      items_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // reprogram all registers, load a full frame, then mix reads with reloads
   task automatic run_phase(input int fw, fh, input mode_type md, input int sx, sy, nw, nh,
                            input logic [PIXEL_W-1:0] fill, input int n_reads);
      logic [CSR_DATA_W-1:0] regs [8];
      int frame_n, out_n;
      wait_idle();
      regs[CSR_FRAME_WIDTH] = CSR_DATA_W'(fw & 'h7f);
      regs[CSR_FRAME_HEIGHT] = CSR_DATA_W'(fh & 'h7f);
      regs[CSR_TRANSFORM_MODE] = CSR_DATA_W'(md);
      regs[CSR_SHIFT_X] = CSR_DATA_W'(sx & 'h7f);
      regs[CSR_SHIFT_Y] = CSR_DATA_W'(sy & 'h7f);
      regs[CSR_NEW_WIDTH] = CSR_DATA_W'(nw & 'h7f);
      regs[CSR_NEW_HEIGHT] = CSR_DATA_W'(nh & 'h7f);
      regs[CSR_FILL_COLOR] = fill;
      for (int i = 0; i < $size(regs); i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data <= regs[i];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_w_raw = CFG_SIZE_W'(fw & 'h7f);
      frame_h_raw = CFG_SIZE_W'(fh & 'h7f);
      xform_mode = md;
      shift_x_reg = CFG_SHIFT_W'(sx & 'h7f);
      shift_y_reg = CFG_SHIFT_W'(sy & 'h7f);
      new_w_raw = CFG_SIZE_W'(nw & 'h7f);
      new_h_raw = CFG_SIZE_W'(nh & 'h7f);
      fill_reg = fill;
      @(negedge clock);
      frame_n = dim(frame_w_raw, MAX_WIDTH) * dim(frame_h_raw, MAX_HEIGHT);
      if (n_reads < 0) begin
         out_n = (md == MODE_CROP_PAD) ?
                 dim(new_w_raw, MAX_WIDTH) * dim(new_h_raw, MAX_HEIGHT) : frame_n;
         n_reads = out_n + $urandom_range(0, out_n);
         if (n_reads > 160) n_reads = $urandom_range(100, 160);
      end
      if (load_ptr >= frame_n) queue_request(FUNC_LOAD, next_pixel());
      repeat (frame_n) queue_request(FUNC_LOAD, next_pixel());
      while (n_reads > 0) begin
         if ($urandom_range(0, 3) == 0) begin
            queue_request(FUNC_LOAD, next_pixel());
         end else begin
            queue_request(FUNC_READ, PIXEL_W'($urandom));
            n_reads--;
         end
      end
      phases_run++;
   endtask

   initial begin
      int fw, fh, random_start;
      directed_pixels = '{24'h000000, 24'hffffff, 24'h800000, 24'h000001, 24'h7f7f7f, 24'h0055aa};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_phase(3, 2, MODE_FLIP_H, 1, -1, 4, 3, 24'hffffff, 7);
      for (int m = MODE_FLIP_V; m <= MODE_PASS; m++)
         run_phase(3, 2, mode_type'(CFG_MODE_W'(m)), 1, -1, 4, 3, 24'h00ff00, 7);

      run_phase(0, 0, MODE_FLIP_V, 0, 0, 0, 0, 24'h000000, 3);
      run_phase(127, 1, MODE_FLIP_H, 0, 0, 64, 64, 24'h000000, 66);
      run_phase(1, 127, MODE_ROT_RIGHT, 0, 0, 64, 64, 24'hffffff, 66);
      run_phase(2, 5, MODE_ROT_LEFT, 0, 0, 64, 64, 24'h3c3c3c, 12);
      run_phase(64, 1, MODE_SHIFT, -63, 0, 64, 64, 24'h123456, 64);
      run_phase(2, 3, MODE_CROP_PAD, 0, 0, 127, 1, 24'hfedcba, 66);
      run_phase(2, 3, MODE_CROP_PAD, 0, 0, 1, 127, 24'h0f0f0f, 66);
      run_phase(5, 4, MODE_CROP_PAD, 0, 0, 3, 2, 24'h000000, 12);
      run_phase(4, 3, MODE_INVERT, 0, 0, 64, 64, 24'hffffff, 14);

      // long output hold while reads keep coming
      run_phase(4, 4, MODE_PASS, 0, 0, 64, 64, 24'h000000, 60);
      hold_request = 1'b1;

      random_start = items_queued;
      while (items_queued - random_start < RANDOM_ITEMS) begin
         fw = pick_size();
         fh = pick_size();
         if (dim(CFG_SIZE_W'(fw), MAX_WIDTH) * dim(CFG_SIZE_W'(fh), MAX_HEIGHT) > 192)
            fh = $urandom_range(1, 3);
         run_phase(fw, fh, mode_type'(CFG_MODE_W'($urandom_range(0, 7))), pick_shift(),
                   pick_shift(), pick_size(), pick_size(), PIXEL_W'($urandom), -1);
      end

      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid);
      for (int k = 0; k < 2000 && expected_pixels.size() != 0; k++) @(negedge clock);
      repeat (8) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never came out", expected_pixels.size());
         error_count++;
      end
      $display("%0d pixel loads and %0d pixel reads over %0d register settings, %0d frames ended",
               loads_done, reads_done, phases_run, frames_done);
      $display("all modes, size saturation, shift and crop extremes and a long output hold ran");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
